// ===== rtl/core/dtc_pkg.sv =====
// Shared types, constants and the exponential table for the difficulty-to-target check.
// No dependencies. The table is computed at elaboration in 512-bit fixed point.
`timescale 1ns / 1ps
`default_nettype none

package dtc_pkg;

    localparam int unsigned WordW   = 256;
    localparam int unsigned FracW   = 512;
    localparam int unsigned RomSize = 256;
    localparam int unsigned SeriesN = 80;

    localparam logic [7:0] IdxLast = 8'hFF;

    localparam logic [0:0] CfgMinDiff = 1'b0;
    localparam logic [0:0] CfgMaxDiff = 1'b1;

    localparam logic [31:0] MinDiffReset = 32'h0000_0000;
    localparam logic [31:0] MaxDiffReset = 32'h0100_0000;

    typedef logic [WordW-1:0] word_t;
    typedef word_t rom_t [RomSize];

    typedef struct packed {
        logic       valid;
        logic       force_ones;
        logic       force_zero;
        logic [7:0] shamt;
    } dtc_ctl_t;

    // Floor of a 512-bit fraction divided by a small integer, shift and subtract.
    function automatic logic [FracW-1:0] fr_div(input logic [FracW-1:0] a,
                                                input logic [9:0] d);
        logic [FracW-1:0] q;
        logic [10:0]      rem;
        q   = '0;
        rem = '0;
        for (int i = FracW - 1; i >= 0; i--) begin
            rem = {rem[9:0], a[i]};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Product of two fractions, truncated to the upper half.
    function automatic logic [FracW-1:0] fr_mul(input logic [FracW-1:0] a,
                                                input logic [FracW-1:0] b);
        logic [2*FracW-1:0] p;
        p = {{FracW{1'b0}}, a} * {{FracW{1'b0}}, b};
        return p[2*FracW-1:FracW];
    endfunction

    // Entry i holds floor(2^256 * 2^(-i/256)); entry 0 is all ones.
    function automatic rom_t build_rom();
        rom_t             rom;
        logic [FracW-1:0] ln2;
        logic [FracW-1:0] t;
        logic [FracW-1:0] y;
        logic [FracW-1:0] term;
        logic [FracW-1:0] pos;
        logic [FracW-1:0] neg;
        logic [FracW-1:0] r;
        logic [FracW-1:0] p;
        ln2 = '0;
        for (int k = 1; k < FracW; k++) begin
            t   = FracW'(1) << (FracW - k);
            t   = fr_div(t, 10'(k));
            ln2 = ln2 + t;
        end
        y    = ln2 >> 8;
        term = y;
        pos  = y;
        neg  = '0;
        for (int n = 2; n < SeriesN; n++) begin
            term = fr_mul(term, y);
            term = fr_div(term, 10'(n));
            if ((n % 2) == 1) begin
                pos = pos + term;
            end else begin
                neg = neg + term;
            end
        end
        t = pos - neg;
        r = '0 - t;
        p = r;
        rom[0] = '1;
        for (int i = 1; i < RomSize; i++) begin
            rom[i] = p[FracW-1:FracW-WordW];
            p      = fr_mul(p, r);
        end
        return rom;
    endfunction

    localparam rom_t Rom = build_rom();

endpackage

`default_nettype wire

// ===== rtl/core/dtc_interp.sv =====
// Table lookup, weighted difference and interpolation: three register stages.
// Depends on dtc_pkg (table, control struct).
`timescale 1ns / 1ps
`default_nettype none

module dtc_interp (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [31:0]       bits_q,
    input  wire dtc_pkg::word_t    commit_in,
    input  wire logic [31:0]       min_difficulty,
    input  wire logic [31:0]       max_difficulty,
    output dtc_pkg::dtc_ctl_t      ctl_out,
    output dtc_pkg::word_t         interp_out,
    output dtc_pkg::word_t         commit_out
);

    dtc_pkg::dtc_ctl_t ctl_next;
    logic [7:0]        idx0;
    logic [7:0]        idx1;

    dtc_pkg::dtc_ctl_t ctl1_reg, ctl2_reg, ctl3_reg;
    dtc_pkg::word_t    v0_1_reg, v1_1_reg, com1_reg;
    logic [7:0]        w1_reg;
    dtc_pkg::word_t    v0_2_reg, adj2_reg, com2_reg;
    dtc_pkg::word_t    interp3_reg, com3_reg;

    logic [263:0]      prod;

    always_comb begin
        ctl_next.valid      = in_valid;
        ctl_next.force_ones = (bits_q <= min_difficulty);
        ctl_next.force_zero = (bits_q >= max_difficulty) || (bits_q[31:24] != 8'h00);
        ctl_next.shamt      = bits_q[23:16];
        idx0                = bits_q[15:8];
        idx1                = (idx0 < dtc_pkg::IdxLast) ? idx0 + 8'd1 : dtc_pkg::IdxLast;
    end

    assign prod = {8'h00, v0_1_reg - v1_1_reg} * {256'h0, w1_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end else if (en) begin
            ctl1_reg <= ctl_next;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v0_1_reg    <= dtc_pkg::Rom[idx0];
            v1_1_reg    <= dtc_pkg::Rom[idx1];
            w1_reg      <= bits_q[7:0];
            com1_reg    <= commit_in;

            v0_2_reg    <= v0_1_reg;
            adj2_reg    <= prod[263:8];
            com2_reg    <= com1_reg;

            interp3_reg <= v0_2_reg - adj2_reg;
            com3_reg    <= com2_reg;
        end
    end

    assign ctl_out    = ctl3_reg;
    assign interp_out = interp3_reg;
    assign commit_out = com3_reg;

endmodule

`default_nettype wire

// ===== rtl/core/dtc_shift.sv =====
// Exponent shift and saturation of the interpolated value, one register stage.
// Depends on dtc_pkg (control struct, word type).
`timescale 1ns / 1ps
`default_nettype none

module dtc_shift (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire dtc_pkg::dtc_ctl_t ctl_in,
    input  wire dtc_pkg::word_t    interp_in,
    input  wire dtc_pkg::word_t    commit_in,
    output logic                   valid_out,
    output dtc_pkg::word_t         target_out,
    output dtc_pkg::word_t         commit_out
);

    dtc_pkg::word_t target_next;
    logic           valid_reg;
    dtc_pkg::word_t target_reg;
    dtc_pkg::word_t commit_reg;

    // Minimum wins over maximum.
    always_comb begin
        priority if (ctl_in.force_ones) begin
            target_next = '1;
        end else if (ctl_in.force_zero) begin
            target_next = '0;
        end else begin
            target_next = interp_in >> ctl_in.shamt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            target_reg <= target_next;
            commit_reg <= commit_in;
        end
    end

    assign valid_out  = valid_reg;
    assign target_out = target_reg;
    assign commit_out = commit_reg;

endmodule

`default_nettype wire

// ===== rtl/core/dtc_compare.sv =====
// Commitment against target compare and the output register.
// Depends on dtc_pkg (word type).
`timescale 1ns / 1ps
`default_nettype none

module dtc_compare (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  wire logic           valid_in,
    input  wire dtc_pkg::word_t target_in,
    input  wire dtc_pkg::word_t commit_in,
    output logic                valid_out,
    output dtc_pkg::word_t      target_out,
    output logic                meets_out
);

    logic           valid_reg;
    dtc_pkg::word_t target_reg;
    logic           meets_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            target_reg <= target_in;
            meets_reg  <= (commit_in <= target_in);
        end
    end

    assign valid_out  = valid_reg;
    assign target_out = target_reg;
    assign meets_out  = meets_reg;

endmodule

`default_nettype wire

// ===== rtl/core/difficulty_to_target_check.sv =====
// A result word passes the input register, the dtc_interp stages, dtc_shift and dtc_compare.
// Throughput: one word per cycle; the six-stage pipeline advances as a whole
// whenever the output register is empty or being taken, and s_axis_tready is that same enable.
// Reset: synchronous active-low aresetn empties the pipeline and sets
// min_difficulty to 0 and max_difficulty to 0x01000000. No clearing pass.
// Depends on dtc_pkg, dtc_interp, dtc_shift, dtc_compare.
`timescale 1ns / 1ps
`default_nettype none

module difficulty_to_target_check (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // Input stream
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [31:0] bits_q, [95:32] commit_w0, [159:96] commit_w1,
    // [223:160] commit_w2, [287:224] commit_w3
    input  wire logic [287:0] s_axis_tdata,
    // Result stream
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [63:0] target_w0, [127:64] target_w1, [191:128] target_w2,
    // [255:192] target_w3, [256] meets, [263:257] zero
    output logic [263:0]      m_axis_tdata,
    // Configuration writes: index 0 min_difficulty, index 1 max_difficulty
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [7:0]   cfg_addr,
    input  wire logic [31:0]  cfg_data
);

    logic              en;
    logic              in_valid_reg;
    logic [31:0]       bits_reg;
    dtc_pkg::word_t    commit_reg;
    logic [31:0]       min_diff_reg;
    logic [31:0]       max_diff_reg;

    dtc_pkg::dtc_ctl_t ctl_c;
    dtc_pkg::word_t    interp_c;
    dtc_pkg::word_t    commit_c;
    logic              valid_d;
    dtc_pkg::word_t    target_d;
    dtc_pkg::word_t    commit_d;
    dtc_pkg::word_t    target_e;
    logic              meets_e;

    // Advance every stage together while the output register can move.
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign cfg_ready     = 1'b1;

    // Register settings; writes to other indexes drop.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_diff_reg <= dtc_pkg::MinDiffReset;
            max_diff_reg <= dtc_pkg::MaxDiffReset;
        end else if (cfg_valid && (cfg_addr[7:1] == 7'd0)) begin
            if (cfg_addr[0] == dtc_pkg::CfgMinDiff) begin
                min_diff_reg <= cfg_data;
            end
            if (cfg_addr[0] == dtc_pkg::CfgMaxDiff) begin
                max_diff_reg <= cfg_data;
            end
        end
    end

    // Input register: hold the accepted word, commitment packed big-endian.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bits_reg   <= s_axis_tdata[31:0];
            commit_reg <= {s_axis_tdata[95:32], s_axis_tdata[159:96],
                           s_axis_tdata[223:160], s_axis_tdata[287:224]};
        end
    end

    dtc_interp u_interp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (en),
        .in_valid       (in_valid_reg),
        .bits_q         (bits_reg),
        .commit_in      (commit_reg),
        .min_difficulty (min_diff_reg),
        .max_difficulty (max_diff_reg),
        .ctl_out        (ctl_c),
        .interp_out     (interp_c),
        .commit_out     (commit_c)
    );

    dtc_shift u_shift (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .ctl_in     (ctl_c),
        .interp_in  (interp_c),
        .commit_in  (commit_c),
        .valid_out  (valid_d),
        .target_out (target_d),
        .commit_out (commit_d)
    );

    dtc_compare u_compare (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .valid_in   (valid_d),
        .target_in  (target_d),
        .commit_in  (commit_d),
        .valid_out  (m_axis_tvalid),
        .target_out (target_e),
        .meets_out  (meets_e)
    );

    // Unpack the target so its most significant word lands lowest.
    assign m_axis_tdata = {7'b0, meets_e, target_e[63:0], target_e[127:64],
                           target_e[191:128], target_e[255:192]};

endmodule

`default_nettype wire

// ===== rtl/core/dtc_checker.sv =====
// Port-level checks on the difficulty-to-target check, bound to the top level.
// Depends on difficulty_to_target_check ports only.
`timescale 1ns / 1ps
`default_nettype none

module dtc_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [263:0] m_axis_tdata,
    input wire logic         cfg_ready
);

    // An empty output always lets a word in.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // An all-ones target is met by any commitment.
    a_ones_meets: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tdata[255:0] == {256{1'b1}})) |-> m_axis_tdata[256])
        else $error("all-ones target not met");

    // Padding above the flag stays zero.
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[263:257] == 7'd0))
        else $error("padding bits set");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("configuration channel blocked");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result word changed");

endmodule

bind difficulty_to_target_check dtc_checker u_dtc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_ready     (cfg_ready)
);

`default_nettype wire
